/* rtl/core/bale_pkg.sv */
package bale_pkg;

	localparam int CAPACITY_DEF = 16;

	typedef enum logic [3:0] {
		FN_INS_FIRST = 4'd0,
		FN_INS_LAST  = 4'd1,
		FN_INS_AT    = 4'd2,
		FN_DEL_FIRST = 4'd3,
		FN_DEL_LAST  = 4'd4,
		FN_DEL_AT    = 4'd5,
		FN_UPDATE    = 4'd6,
		FN_SEARCH    = 4'd7,
		FN_CLEAR     = 4'd8
	} func_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_FULL   = 2'd1,
		STS_BADPOS = 2'd2
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [3:0]  position;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		status_t    status;
		logic [4:0] found_index;
		logic       found;
		logic [4:0] count;
	} res_t;

endpackage

/* rtl/core/bounded_array_list_engine_core.sv */
// channel   direction  handshake              payload
// command   in         start high, busy low   cmd (cmd_t: func, position, value)
// result    out        done pulse, one cycle  res (res_t: status, found_index, found, count)
//
// one entry store with a single write port and a single registered read port
// carries all shifting and searching, one entry per cycle:
// an insert with shift copies entries up in ST_UP, then writes the new value in ST_PUT;
// delete with shift copies entries down in ST_DN; search scans from index 0 in ST_SRCH;
// other commands finish when accepted; done comes in the cycle after the command finishes.
// arst_n clears the count and the sequencer; entry contents are not cleared.
// done is high for one cycle only and cannot be held off; res stays until the next command.
module bounded_array_list_engine_core
	import bale_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = CW + 4;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UP   = 5'b00010,
		ST_PUT  = 5'b00100,
		ST_DN   = 5'b01000,
		ST_SRCH = 5'b10000
	} state_t;

	logic [31:0] mem [CAPACITY];

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [31:0]   val_q, val_d;
	logic          wpend_q, wpend_d;
	logic [AW-1:0] widx_q, widx_d;
	logic          cvalid_q, cvalid_d;
	logic [AW-1:0] cidx_q, cidx_d;
	logic          done_q, done_d;
	res_t          res_q, res_d;
	logic [31:0]   rdata_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr;

	logic [CW-1:0] idx_m1, idx_p1;
	logic [EW-1:0] pos_e, cnt_e, ins_e, del_e;

	assign idx_m1 = idx_q - 1'b1;
	assign idx_p1 = idx_q + 1'b1;
	assign pos_e  = EW'(cmd.position);
	assign cnt_e  = EW'(cnt_q);

	always_comb begin
		priority if (cmd.func == FN_INS_FIRST) begin
			ins_e = '0;
		end else if (cmd.func == FN_INS_LAST) begin
			ins_e = cnt_e;
		end else begin
			ins_e = pos_e;
		end
		del_e = (cmd.func == FN_DEL_FIRST) ? '0 : pos_e;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		val_d    = val_q;
		wpend_d  = 1'b0;
		widx_d   = widx_q;
		cvalid_d = 1'b0;
		cidx_d   = cidx_q;
		done_d   = 1'b0;
		res_d    = res_q;
		we       = 1'b0;
		waddr    = widx_q;
		wdata    = rdata_q;
		raddr    = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_d  = '0;
					done_d = 1'b1;
					unique case (cmd.func)
						FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
							priority if (cnt_q == CW'(CAPACITY)) begin
								res_d.status = STS_FULL;
							end else if (ins_e > cnt_e) begin
								res_d.status = STS_BADPOS;
							end else if (ins_e == cnt_e) begin
								we    = 1'b1;
								waddr = ins_e[AW-1:0];
								wdata = cmd.value;
								cnt_d = cnt_q + 1'b1;
							end else begin
								done_d  = 1'b0;
								state_d = ST_UP;
								idx_d   = cnt_q;
								pos_d   = ins_e[CW-1:0];
								val_d   = cmd.value;
							end
						end
						FN_DEL_FIRST, FN_DEL_AT: begin
							priority if (cnt_q == '0 && del_e == '0) begin
								res_d.status = STS_OK;
							end else if (del_e >= cnt_e) begin
								res_d.status = STS_BADPOS;
							end else if (del_e + 1'b1 == cnt_e) begin
								cnt_d = cnt_q - 1'b1;
							end else begin
								done_d  = 1'b0;
								state_d = ST_DN;
								idx_d   = del_e[CW-1:0];
							end
						end
						FN_DEL_LAST: begin
							if (cnt_q != '0) begin
								cnt_d = cnt_q - 1'b1;
							end
						end
						FN_UPDATE: begin
							if (pos_e >= EW'(CAPACITY)) begin
								res_d.status = STS_BADPOS;
							end else begin
								we    = 1'b1;
								waddr = pos_e[AW-1:0];
								wdata = cmd.value;
							end
						end
						FN_SEARCH: begin
							if (cnt_q != '0) begin
								done_d  = 1'b0;
								state_d = ST_SRCH;
								idx_d   = '0;
								val_d   = cmd.value;
							end
						end
						FN_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
							res_d.status = STS_OK;
						end
					endcase
				end
			end
			ST_UP: begin
				we = wpend_q;
				if (idx_q > pos_q) begin
					raddr   = idx_m1[AW-1:0];
					wpend_d = 1'b1;
					widx_d  = idx_q[AW-1:0];
					idx_d   = idx_m1;
				end else begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				we      = 1'b1;
				waddr   = pos_q[AW-1:0];
				wdata   = val_q;
				cnt_d   = cnt_q + 1'b1;
				res_d   = '0;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DN: begin
				we = wpend_q;
				if (idx_p1 < cnt_q) begin
					raddr   = idx_p1[AW-1:0];
					wpend_d = 1'b1;
					widx_d  = idx_q[AW-1:0];
					idx_d   = idx_p1;
				end else begin
					cnt_d   = cnt_q - 1'b1;
					res_d   = '0;
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SRCH: begin
				priority if (cvalid_q && rdata_q == val_q) begin
					res_d             = '0;
					res_d.found       = 1'b1;
					res_d.found_index = 5'(cidx_q);
					done_d            = 1'b1;
					state_d           = ST_IDLE;
				end else if (idx_q < cnt_q) begin
					raddr    = idx_q[AW-1:0];
					cidx_d   = idx_q[AW-1:0];
					cvalid_d = 1'b1;
					idx_d    = idx_p1;
				end else begin
					res_d             = '0;
					res_d.found_index = 5'(cnt_q);
					done_d            = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (done_d) begin
			res_d.count = 5'(cnt_d);
		end
	end

	// entry store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			wpend_q  <= 1'b0;
			cvalid_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
			wpend_q  <= wpend_d;
			cvalid_q <= cvalid_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		val_q  <= val_d;
		widx_q <= widx_d;
		cidx_q <= cidx_d;
		res_q  <= res_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
	import bale_pkg::*;
;

	localparam int RANDOM_ITEMS = 750;
	localparam int QUIET_TAIL = 120;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [31:0] VALUE_POOL [6] = '{
		32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
		32'h8000_0000, 32'h7fff_ffff, 32'h5a5a_5a5a
	};

	class list_mirror;
		logic [31:0] slots [CAPACITY_DEF];
		int unsigned used;
		res_t awaited [$];
		int unsigned faults;

		function status_t put(int unsigned at, logic [31:0] v);
			if (used >= CAPACITY_DEF) return STS_FULL;
			if (at > used) return STS_BADPOS;
			for (int unsigned i = used; i > at; i--) slots[i] = slots[i - 1];
			slots[at] = v;
			used++;
			return STS_OK;
		endfunction

		function void take(int unsigned at);
			for (int unsigned i = at; i + 1 < used; i++) slots[i] = slots[i + 1];
			used--;
		endfunction

		function void apply_command(cmd_t c);
			res_t r;
			int unsigned p;
			r = '0;
			r.status = STS_OK;
			p = c.position;
			case (c.func)
				FN_INS_FIRST: r.status = put(0, c.value);
				FN_INS_LAST: r.status = put(used, c.value);
				FN_INS_AT: r.status = put(p, c.value);
				FN_DEL_FIRST: if (used != 0) take(0);
				FN_DEL_LAST: if (used != 0) used--;
				FN_DEL_AT: begin
					if (!(used == 0 && p == 0)) begin
						if (p >= used) r.status = STS_BADPOS;
						else take(p);
					end
				end
				FN_UPDATE: begin
					if (p >= CAPACITY_DEF) r.status = STS_BADPOS;
					else slots[p] = c.value;
				end
				FN_SEARCH: begin
					r.found_index = 5'(used);
					for (int unsigned i = 0; i < used; i++) begin
						if (slots[i] == c.value) begin
							r.found_index = 5'(i);
							r.found = 1'b1;
							break;
						end
					end
				end
				FN_CLEAR: used = 0;
				default: ;
			endcase
			r.count = 5'(used);
			awaited = {awaited, r};
		endfunction

		function void match_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				$display("%0t: expected no result, actual %h", $time, got);
				faults++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				faults++;
			end
			if (got.found_index !== want.found_index) begin
				$display("%0t: found_index expected %0d actual %0d", $time,
					want.found_index, got.found_index);
				faults++;
			end
			if (got.found !== want.found) begin
				$display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
				faults++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
				faults++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	res_t res;

	list_mirror mirror;
	int unsigned stall_cycles = 0;

	bounded_array_list_engine_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.res(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) mirror.match_result(res);
			if ((start && !busy) || done) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	task automatic issue(input cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy !== 1'b0);
		mirror.apply_command(c);
	endtask

	task automatic pause(input int unsigned cycles);
		logic [39:0] noise;
		noise = 40'({$urandom, $urandom});
		start <= 1'b0;
		cmd <= cmd_t'(noise);
		repeat (cycles) @(posedge clk);
	endtask

	function automatic cmd_t make_cmd(func_t f, logic [3:0] p, logic [31:0] v);
		cmd_t c;
		c.func = f;
		c.position = p;
		c.value = v;
		return c;
	endfunction

	function automatic logic [31:0] some_value();
		if ($urandom_range(0, 9) < 4) return VALUE_POOL[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	function automatic cmd_t next_command(int unsigned grow_pct);
		cmd_t c;
		int unsigned n;
		int unsigned roll;
		n = mirror.used;
		c.func = FN_SEARCH;
		c.position = 4'($urandom_range(0, 15));
		c.value = some_value();
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			c.func = FN_CLEAR;
		end else if (roll < 4) begin
			c.func = func_t'(4'($urandom_range(int'(FN_CLEAR) + 1, 15)));
		end else if (roll < 14) begin
			if (n != 0 && $urandom_range(0, 2) != 0)
				c.value = mirror.slots[$urandom_range(0, n - 1)];
		end else if (roll < 22) begin
			c.func = FN_UPDATE;
		end else if ($urandom_range(0, 99) < grow_pct) begin
			case ($urandom_range(0, 2))
				0: c.func = FN_INS_FIRST;
				1: c.func = FN_INS_LAST;
				default: c.func = FN_INS_AT;
			endcase
			if ($urandom_range(0, 4) != 0) c.position = 4'($urandom_range(0, n < 15 ? n : 15));
		end else begin
			case ($urandom_range(0, 2))
				0: c.func = FN_DEL_FIRST;
				1: c.func = FN_DEL_LAST;
				default: c.func = FN_DEL_AT;
			endcase
			if (n != 0 && $urandom_range(0, 4) != 0) c.position = 4'($urandom_range(0, n - 1));
		end
		return c;
	endfunction

	initial begin
		int unsigned sent;
		int unsigned span;
		int unsigned idle_pct;
		int unsigned grow_pct;
		bit growing;
		mirror = new;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		issue(make_cmd(FN_DEL_FIRST, 4'd0, 32'h0));
		issue(make_cmd(FN_DEL_LAST, 4'd0, 32'h0));
		issue(make_cmd(FN_DEL_AT, 4'd0, 32'h0));
		issue(make_cmd(FN_DEL_AT, 4'd5, 32'h0));
		issue(make_cmd(FN_SEARCH, 4'd0, 32'h0));
		issue(make_cmd(FN_INS_AT, 4'd1, 32'h1));
		// build and probe a short list
		issue(make_cmd(FN_INS_FIRST, 4'd0, 32'h7fff_ffff));
		issue(make_cmd(FN_INS_LAST, 4'd15, 32'h8000_0000));
		issue(make_cmd(FN_INS_AT, 4'd1, 32'hffff_ffff));
		issue(make_cmd(FN_INS_AT, 4'd4, 32'h2));
		issue(make_cmd(FN_INS_FIRST, 4'd0, 32'h8000_0000));
		issue(make_cmd(FN_SEARCH, 4'd0, 32'h8000_0000));
		issue(make_cmd(FN_SEARCH, 4'd0, 32'h1234_5678));
		issue(make_cmd(FN_UPDATE, 4'd15, 32'ha5a5_a5a5));
		issue(make_cmd(FN_UPDATE, 4'd0, 32'h0));
		issue(make_cmd(FN_DEL_AT, 4'd1, 32'h0));
		issue(make_cmd(FN_DEL_AT, 4'd15, 32'h0));
		issue(make_cmd(func_t'(4'(int'(FN_CLEAR) + 1)), 4'd3, 32'h3));
		issue(make_cmd(func_t'(4'hf), 4'hf, 32'hffff_ffff));
		issue(make_cmd(FN_SEARCH, 4'd0, 32'hffff_ffff));
		issue(make_cmd(FN_DEL_LAST, 4'd0, 32'h0));
		issue(make_cmd(FN_CLEAR, 4'd0, 32'h0));
		issue(make_cmd(FN_SEARCH, 4'd0, 32'h0));

		// alternating grow and shrink phases so the store fills and drains
		sent = 0;
		growing = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			span = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 25;
				default: idle_pct = 60;
			endcase
			grow_pct = growing ? 85 : 25;
			growing = !growing;
			for (int unsigned k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
				if (sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
					pause($urandom_range(1, 10));
				issue(next_command(grow_pct));
				sent++;
			end
		end
		start <= 1'b0;

		while (mirror.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.faults == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
